@@ rtl/mlseq_pkg.sv @@
// Shared types, codes and constants of the magnetometer link sequencer.
`default_nettype none
package mlseq_pkg;

  // Default record length in bytes (legal range 2 to 32; the query index is 5 bits)
  localparam int unsigned RECORD_BYTES = 28;

  // Bytes in one sensor command
  localparam int unsigned CMD_BYTES = 9;

  // Configuration register indexes
  localparam logic [1:0] CFG_CYCLE_COUNT   = 2'd0;
  localparam logic [1:0] CFG_FREQ_SETTING  = 2'd1;
  localparam logic [1:0] CFG_RETRIEVE_MODE = 2'd2;

  // Configuration reset values
  localparam logic [15:0] CYCLE_COUNT_RST   = 16'h0320;
  localparam logic [7:0]  FREQ_SETTING_RST  = 8'h1E;
  localparam logic [7:0]  RETRIEVE_MODE_RST = 8'h01;

  // Command opcodes and fill byte
  localparam logic [7:0] OP_SET_COUNT  = 8'h01;
  localparam logic [7:0] OP_READ_COUNT = 8'h02;
  localparam logic [7:0] OP_START_MEAS = 8'h03;
  localparam logic [7:0] OP_RETRIEVE   = 8'h05;
  localparam logic [7:0] FILL_BYTE     = 8'hFF;

  // Request types on the input channel
  typedef enum logic [1:0] {
    REQ_POLL    = 2'd0,
    REQ_RX_BYTE = 2'd1,
    REQ_TIMEOUT = 2'd2,
    REQ_QUERY   = 2'd3
  } req_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_CMD    = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_DATA   = 2'd2
  } kind_e;

  // Status codes
  typedef enum logic [2:0] {
    ST_NONE       = 3'd0,
    ST_COUNT_OK   = 3'd1,
    ST_BAD_ECHO   = 3'd2,
    ST_ECHO_TMO   = 3'd3,
    ST_READ_ERROR = 3'd4
  } status_e;

  // Sequence phases
  typedef enum logic [2:0] {
    PH_SET_COUNT  = 3'd0,
    PH_READ_COUNT = 3'd1,
    PH_ECHO_CHECK = 3'd2,
    PH_RETRIEVE   = 3'd3,
    PH_START_MEAS = 3'd4,
    PH_MEASURE    = 3'd5
  } phase_e;

  // One burst of results produced by one request
  typedef struct packed {
    logic                          is_cmd;
    kind_e                         kind;
    status_e                       status;
    logic                          record_done;
    logic [7:0]                    data_byte;
    phase_e                        phase_now;
    logic [CMD_BYTES-1:0][7:0]     cmd;
  } burst_t;

endpackage
`default_nettype wire

@@ rtl/mlseq_core.sv @@
// Request register, sequencer state, record buffers and burst builder.
`default_nettype none
module mlseq_core #(
  parameter int unsigned RECORD_BYTES = mlseq_pkg::RECORD_BYTES
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire logic [15:0]     s_axis_tdata,   // rx_byte[7:0], query_index[12:8]
  input  wire logic [1:0]      s_axis_tuser,   // req_type[1:0]
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_idx_i,
  input  wire logic [15:0]     cfg_data_i,
  input  wire logic            load_ok_i,
  output logic                 burst_valid_o,
  output mlseq_pkg::burst_t    burst_o
);

  localparam int unsigned PosW = $clog2(RECORD_BYTES);
  localparam int unsigned QW   = 5;
  localparam int unsigned WideW = QW + PosW;
  localparam logic [PosW-1:0] LastPos = PosW'(RECORD_BYTES - 1);

  // Configuration registers
  logic [15:0] cycle_count_q;
  logic [7:0]  freq_setting_q;
  logic [7:0]  retrieve_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_count_q   <= mlseq_pkg::CYCLE_COUNT_RST;
      freq_setting_q  <= mlseq_pkg::FREQ_SETTING_RST;
      retrieve_mode_q <= mlseq_pkg::RETRIEVE_MODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mlseq_pkg::CFG_CYCLE_COUNT:   cycle_count_q   <= cfg_data_i;
        mlseq_pkg::CFG_FREQ_SETTING:  freq_setting_q  <= cfg_data_i[7:0];
        mlseq_pkg::CFG_RETRIEVE_MODE: retrieve_mode_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic            in_valid_q;
  mlseq_pkg::req_e req_q;
  logic [7:0]      rx_q;
  logic [QW-1:0]   qi_q;
  logic            advance;

  assign advance       = in_valid_q & load_ok_i;
  assign s_axis_tready = ~in_valid_q | load_ok_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_q <= mlseq_pkg::req_e'(s_axis_tuser);
      rx_q  <= s_axis_tdata[7:0];
      qi_q  <= s_axis_tdata[12:8];
    end
  end

  // Sequencer state
  mlseq_pkg::phase_e phase_q, phase_d;
  logic [1:0]        echo_cnt_q, echo_cnt_d;
  logic [15:0]       echo_q, echo_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [7:0]        asm_q    [RECORD_BYTES];
  logic [7:0]        latest_q [RECORD_BYTES];

  logic echo_ok;
  assign echo_ok = (echo_cnt_q == 2'd2) && (echo_q == cycle_count_q);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (advance) begin
      case (req_q)
        mlseq_pkg::REQ_POLL: begin
          case (phase_q)
            mlseq_pkg::PH_SET_COUNT:  phase_d = mlseq_pkg::PH_READ_COUNT;
            mlseq_pkg::PH_READ_COUNT: phase_d = mlseq_pkg::PH_ECHO_CHECK;
            mlseq_pkg::PH_ECHO_CHECK: begin
              phase_d = echo_ok ? mlseq_pkg::PH_RETRIEVE : mlseq_pkg::PH_SET_COUNT;
            end
            mlseq_pkg::PH_RETRIEVE:   phase_d = mlseq_pkg::PH_START_MEAS;
            mlseq_pkg::PH_START_MEAS: phase_d = mlseq_pkg::PH_MEASURE;
            mlseq_pkg::PH_MEASURE:    phase_d = mlseq_pkg::PH_MEASURE;
            default:                  phase_d = mlseq_pkg::PH_SET_COUNT;
          endcase
        end
        mlseq_pkg::REQ_TIMEOUT: begin
          if (phase_q == mlseq_pkg::PH_ECHO_CHECK || phase_q == mlseq_pkg::PH_MEASURE) begin
            phase_d = mlseq_pkg::PH_SET_COUNT;
          end
        end
        default: ;
      endcase
    end
  end

  // Phase-dependent actions and burst contents
  logic            restart;
  logic            asm_we;
  logic            rec_done;
  logic            is_cmd;
  mlseq_pkg::status_e status;
  logic [mlseq_pkg::CMD_BYTES-1:0][7:0] cmd;

  always_comb begin
    restart    = 1'b0;
    is_cmd     = 1'b0;
    status     = mlseq_pkg::ST_NONE;
    cmd        = '0;
    echo_cnt_d = echo_cnt_q;
    echo_d     = echo_q;
    pos_d      = pos_q;
    asm_we     = 1'b0;
    rec_done   = 1'b0;
    case (req_q)
      mlseq_pkg::REQ_POLL: begin
        case (phase_q)
          mlseq_pkg::PH_SET_COUNT: begin
            is_cmd = 1'b1;
            cmd[0] = mlseq_pkg::OP_SET_COUNT;
            cmd[1] = cycle_count_q[15:8];
            cmd[2] = cycle_count_q[7:0];
          end
          mlseq_pkg::PH_READ_COUNT: begin
            is_cmd     = 1'b1;
            cmd[0]     = mlseq_pkg::OP_READ_COUNT;
            echo_cnt_d = 2'd0;
            echo_d     = 16'd0;
          end
          mlseq_pkg::PH_ECHO_CHECK: begin
            if (echo_cnt_q != 2'd2) begin
              status  = mlseq_pkg::ST_ECHO_TMO;
              restart = 1'b1;
            end else if (echo_ok) begin
              status     = mlseq_pkg::ST_COUNT_OK;
              echo_cnt_d = 2'd0;
            end else begin
              status  = mlseq_pkg::ST_BAD_ECHO;
              restart = 1'b1;
            end
          end
          mlseq_pkg::PH_RETRIEVE: begin
            is_cmd = 1'b1;
            cmd[0] = mlseq_pkg::OP_RETRIEVE;
            cmd[1] = retrieve_mode_q;
          end
          mlseq_pkg::PH_START_MEAS: begin
            is_cmd = 1'b1;
            cmd[0] = mlseq_pkg::OP_START_MEAS;
            cmd[1] = mlseq_pkg::FILL_BYTE;
            cmd[2] = mlseq_pkg::FILL_BYTE;
            cmd[3] = mlseq_pkg::FILL_BYTE;
            cmd[4] = mlseq_pkg::FILL_BYTE;
            cmd[5] = freq_setting_q;
          end
          mlseq_pkg::PH_MEASURE: ;
          default: restart = 1'b1;
        endcase
      end
      mlseq_pkg::REQ_RX_BYTE: begin
        if (phase_q == mlseq_pkg::PH_ECHO_CHECK) begin
          if (echo_cnt_q != 2'd2) begin
            echo_d     = {echo_q[7:0], rx_q};
            echo_cnt_d = echo_cnt_q + 2'd1;
          end
        end else if (phase_q == mlseq_pkg::PH_MEASURE) begin
          asm_we = 1'b1;
          if (pos_q == LastPos) begin
            rec_done = 1'b1;
            pos_d    = '0;
          end else begin
            pos_d = pos_q + PosW'(1);
          end
        end
      end
      mlseq_pkg::REQ_TIMEOUT: begin
        if (phase_q == mlseq_pkg::PH_ECHO_CHECK) begin
          status  = mlseq_pkg::ST_ECHO_TMO;
          restart = 1'b1;
        end else if (phase_q == mlseq_pkg::PH_MEASURE) begin
          status  = mlseq_pkg::ST_READ_ERROR;
          restart = 1'b1;
        end
      end
      default: ;
    endcase
    if (restart) begin
      echo_cnt_d = 2'd0;
      echo_d     = 16'd0;
      pos_d      = '0;
    end
  end

  // Record query read
  logic [WideW-1:0] qi_wide;
  logic [PosW-1:0]  q_idx;
  logic             q_in_range;
  logic [7:0]       q_data;

  assign qi_wide    = {{PosW{1'b0}}, qi_q};
  assign q_idx      = qi_wide[PosW-1:0];
  assign q_in_range = qi_wide < WideW'(RECORD_BYTES);
  assign q_data     = q_in_range ? latest_q[q_idx] : 8'd0;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= mlseq_pkg::PH_SET_COUNT;
      echo_cnt_q <= 2'd0;
      echo_q     <= 16'd0;
      pos_q      <= '0;
    end else if (advance) begin
      phase_q    <= phase_d;
      echo_cnt_q <= echo_cnt_d;
      echo_q     <= echo_d;
      pos_q      <= pos_d;
    end
  end

  // Assembly buffer, written at the running position
  always_ff @(posedge clk_i) begin
    if (advance && asm_we) begin
      asm_q[pos_q] <= rx_q;
    end
  end

  // Latest record: whole-record copy on completion, cleared on restart
  for (genvar i = 0; i < RECORD_BYTES; i++) begin : g_latest
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        latest_q[i] <= 8'd0;
      end else if (advance && restart) begin
        latest_q[i] <= 8'd0;
      end else if (advance && rec_done) begin
        latest_q[i] <= (i == RECORD_BYTES - 1) ? rx_q : asm_q[i];
      end
    end
  end

  // Burst handed to the output stage
  assign burst_valid_o = advance;

  always_comb begin
    burst_o             = '0;
    burst_o.is_cmd      = is_cmd;
    burst_o.cmd         = cmd;
    burst_o.status      = status;
    burst_o.record_done = rec_done;
    burst_o.phase_now   = phase_d;
    if (is_cmd) begin
      burst_o.kind = mlseq_pkg::KIND_CMD;
    end else if (req_q == mlseq_pkg::REQ_QUERY) begin
      burst_o.kind      = mlseq_pkg::KIND_DATA;
      burst_o.data_byte = q_data;
    end else begin
      burst_o.kind = mlseq_pkg::KIND_STATUS;
    end
  end

endmodule
`default_nettype wire

@@ rtl/mlseq_tx.sv @@
// Result register that plays out one burst, one result per beat.
`default_nettype none
module mlseq_tx (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              burst_valid_i,
  input  wire mlseq_pkg::burst_t burst_i,
  output logic                   load_ok_o,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [23:0]            m_axis_tdata,
  output logic [1:0]             m_axis_tuser,
  output logic                   m_axis_tlast
);

  localparam int unsigned BeatW = $clog2(mlseq_pkg::CMD_BYTES);
  localparam logic [BeatW-1:0] LastBeat = BeatW'(mlseq_pkg::CMD_BYTES - 1);

  logic              valid_q;
  logic [BeatW-1:0]  beat_q;
  mlseq_pkg::burst_t burst_q;
  logic              last_beat;

  assign last_beat = ~burst_q.is_cmd | (beat_q == LastBeat);
  assign load_ok_o = ~valid_q | (m_axis_tready & last_beat);

  // Beat control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      beat_q  <= '0;
    end else if (load_ok_o) begin
      valid_q <= burst_valid_i;
      beat_q  <= '0;
    end else if (m_axis_tready) begin
      beat_q <= beat_q + BeatW'(1);
    end
  end

  // Payload: command bytes shift down one per beat
  always_ff @(posedge clk_i) begin
    if (load_ok_o) begin
      burst_q <= burst_i;
    end else if (m_axis_tready) begin
      burst_q.cmd <= {8'h00, burst_q.cmd[mlseq_pkg::CMD_BYTES-1:1]};
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tlast  = last_beat;
  assign m_axis_tuser  = burst_q.kind;
  assign m_axis_tdata  = {1'b0, burst_q.phase_now, burst_q.data_byte,
                          burst_q.record_done, burst_q.status, burst_q.cmd[0]};

endmodule
`default_nettype wire

@@ rtl/magnetometer_link_sequencer_unit.sv @@
// Top level of the magnetometer link sequencer.
// Requests enter on the s_axis channel: tuser carries the request type (poll,
// received byte, receive timeout, record query), tdata the received byte and
// the query index. Results leave on m_axis: tuser is the result kind, tdata
// holds command byte, status, record-done flag, queried byte and the phase,
// tlast marks the final result of a request.
// A poll in a command phase yields nine command bytes; every other request
// yields one result. A request passes through the input register, then the
// result register, before its first result. One request is accepted per cycle
// while single results flow; a command burst holds the input for nine beats,
// set by the one-beat-per-cycle result register.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
// idle. Reset returns to the set-count phase, clears the echo and record
// state and the latest record, and restores the default register values.
// When the receiver stalls, results hold and the input fills and then stalls.
`default_nettype none
module magnetometer_link_sequencer_unit #(
  parameter int unsigned RECORD_BYTES = mlseq_pkg::RECORD_BYTES
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // rx_byte[7:0], query_index[12:8]
  input  wire logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // tx_byte[7:0], status[10:8],
                                           // record_done[11], data_byte[19:12],
                                           // phase_now[22:20]
  output logic [1:0]       m_axis_tuser,   // kind[1:0]
  output logic             m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  logic              load_ok;
  logic              burst_valid;
  mlseq_pkg::burst_t burst;

  // Request decode and sequencer state
  mlseq_core #(
    .RECORD_BYTES(RECORD_BYTES)
  ) u_core (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .load_ok_i     (load_ok),
    .burst_valid_o (burst_valid),
    .burst_o       (burst)
  );

  // Result playout
  mlseq_tx u_tx (
    .clk_i,
    .rst_ni,
    .burst_valid_i (burst_valid),
    .burst_i       (burst),
    .load_ok_o     (load_ok),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

endmodule
`default_nettype wire
